>>> hdl/block_epistasis_permute_macros.svh
// Assertion macros used by the checker file of the epistasis-permute block.
`ifndef BLOCK_EPISTASIS_PERMUTE_MACROS_SVH
`define BLOCK_EPISTASIS_PERMUTE_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define BEP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BEP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/bep_pkg.sv
// Shared constants and types of the epistasis-permute block.
package bep_pkg;

   localparam int VEC_W             = 64;
   localparam int POS_W             = 6;
   localparam int CFG_W             = 7;
   localparam int CSR_IDX_W         = 2;
   localparam int DEF_MAX_DIMENSION = 64;

   localparam logic CMD_WRITE     = 1'b0;
   localparam logic CMD_TRANSFORM = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_BLK_LEN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSION = 2'd1;

   localparam logic [CFG_W-1:0] BLK_LEN_RESET   = 7'd1;
   localparam logic [CFG_W-1:0] DIMENSION_RESET = 7'd64;

   // Per-lane view of the block layout: block start minus one, block end,
   // and the one position left out of the block parity.
   typedef struct packed {
      logic             valid;
      logic             s_nz;
      logic [POS_W-1:0] sp;
      logic [POS_W-1:0] e;
      logic             xv;
      logic [POS_W-1:0] x;
   } lane_cfg_type;

endpackage

>>> hdl/bep_sweep.sv
// Layout sequencer: walks the bit positions once and builds each lane's block layout.
module bep_sweep #(
   parameter int MAX_DIMENSION = bep_pkg::DEF_MAX_DIMENSION
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       restart,
   input  logic [bep_pkg::CFG_W-1:0]  blk_len,
   input  logic [bep_pkg::CFG_W-1:0]  dimension,
   output logic                       busy,
   output bep_pkg::lane_cfg_type      lane_cfg [MAX_DIMENSION]
);

   localparam int PW = bep_pkg::POS_W;
   localparam int CW = bep_pkg::CFG_W;
   localparam logic [PW-1:0] LAST_POS  = PW'(MAX_DIMENSION - 1);
   localparam logic [CW-1:0] MAX_DIM_C = CW'(MAX_DIMENSION);

   logic                  busy_ff, busy_in;
   logic [PW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         h_ff, h_in;
   bep_pkg::lane_cfg_type cfg_ff [MAX_DIMENSION];
   bep_pkg::lane_cfg_type cfg_in;

   logic [CW-1:0] bs_eff, dim_eff, pos, rem, v, i, j, hm1;
   logic [1:0]    m;
   logic          last;

   // layout of the position under the counter
   always_comb begin
      bs_eff  = (blk_len == '0) ? CW'(1) : blk_len;
      dim_eff = (dimension > MAX_DIM_C) ? MAX_DIM_C : dimension;
      pos     = {1'b0, cnt_ff};
      rem     = dim_eff - h_ff;
      v       = (rem > bs_eff) ? bs_eff : rem;
      i       = pos - h_ff;
      last    = ((i + CW'(1)) == v);
      m       = 2'(v - i - CW'(2));
      j       = v - CW'(1) - {{(CW-2){1'b0}}, m};
      hm1     = h_ff - CW'(1);

      cfg_in.valid = (pos < dim_eff);
      cfg_in.s_nz  = (h_ff != '0);
      cfg_in.sp    = hm1[PW-1:0];
      cfg_in.e     = PW'(h_ff + v - CW'(1));
      cfg_in.xv    = !last;
      cfg_in.x     = PW'(h_ff + j);
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      h_in    = h_ff;
      if (restart) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         h_in    = '0;
      end else if (busy_ff) begin
         busy_in = (cnt_ff != LAST_POS);
         cnt_in  = cnt_ff + PW'(1);
         h_in    = last ? (pos + CW'(1)) : h_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         h_ff    <= '0;
         for (int k = 0; k < MAX_DIMENSION; k++) begin
            cfg_ff[k] <= '0;
         end
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         h_ff    <= h_in;
         for (int k = 0; k < MAX_DIMENSION; k++) begin
            if (busy_ff && cnt_ff == PW'(k)) begin
               cfg_ff[k] <= cfg_in;
            end
         end
      end
   end

   assign busy     = busy_ff;
   assign lane_cfg = cfg_ff;

endmodule

>>> hdl/bep_lane.sv
// One epistasis lane: block parity minus the excluded bit, from prefix parities.
module bep_lane (
   input  logic [bep_pkg::VEC_W-1:0] prefix,
   input  logic [bep_pkg::VEC_W-1:0] vec,
   input  bep_pkg::lane_cfg_type     cfg,
   output logic                      epi_bit
);

   assign epi_bit = cfg.valid & (prefix[cfg.e]
                                 ^ (cfg.s_nz & prefix[cfg.sp])
                                 ^ (cfg.xv & vec[cfg.x]));

endmodule

>>> hdl/bep_permute.sv
// Merge stage: permutation entries and the crossbar that gathers the lane results.
module bep_permute #(
   parameter int MAX_DIMENSION = bep_pkg::DEF_MAX_DIMENSION
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [bep_pkg::POS_W-1:0]  wr_idx,
   input  logic [bep_pkg::POS_W-1:0]  wr_val,
   input  logic [MAX_DIMENSION-1:0]   lane_en,
   input  logic [bep_pkg::VEC_W-1:0]  epi,
   output logic [bep_pkg::VEC_W-1:0]  perm
);

   localparam int PW = bep_pkg::POS_W;

   logic [PW-1:0] tab_ff [MAX_DIMENSION];
   logic [PW-1:0] tab_in [MAX_DIMENSION];

   // indexes at or above the depth match no entry and drop out
   always_comb begin
      for (int k = 0; k < MAX_DIMENSION; k++) begin
         tab_in[k] = (wr_en && wr_idx == PW'(k)) ? wr_val : tab_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_DIMENSION; k++) begin
            tab_ff[k] <= PW'(k);
         end
      end else begin
         for (int k = 0; k < MAX_DIMENSION; k++) begin
            tab_ff[k] <= tab_in[k];
         end
      end
   end

   // lanes at or above the dimension are zero, so out-of-range sources read zero
   for (genvar k = 0; k < bep_pkg::VEC_W; k++) begin : g_bit
      if (k < MAX_DIMENSION) begin : g_used
         assign perm[k] = lane_en[k] & epi[tab_ff[k]];
      end else begin : g_unused
         assign perm[k] = 1'b0;
      end
   end

endmodule

>>> hdl/block_epistasis_permute.sv
// Top level of the epistasis-permute block: handshake, pipeline and lanes.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------------------------------
//   req      | req_valid / req_stall    | command, vector_bits, table_index, table_value
//   rsp      | rsp_valid / rsp_stall    | result_bits
//   csr      | csr_valid / csr_ready    | csr_index, csr_wdata
//
// One item per cycle unless req_stall is high; a transform result moves through stage a,
// stage b and the result register before it appears on rsp.
// The lane layout comes from a sequencer that walks MAX_DIMENSION positions, one a
// cycle, after reset and after every csr transfer; req_stall stays high meanwhile.
// Reset is synchronous: it clears the pipeline and restores the identity permutation.
// A held rsp_stall freezes the result register; upstream stages keep filling.
module block_epistasis_permute #(
   parameter int MAX_DIMENSION = bep_pkg::DEF_MAX_DIMENSION
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [bep_pkg::VEC_W-1:0]     req_vector_bits,
   input  logic [bep_pkg::POS_W-1:0]     req_table_index,
   input  logic [bep_pkg::POS_W-1:0]     req_table_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bep_pkg::VEC_W-1:0]     rsp_result_bits,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bep_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bep_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int VW = bep_pkg::VEC_W;
   localparam int PW = bep_pkg::POS_W;
   localparam int CW = bep_pkg::CFG_W;

   // configuration registers
   logic [CW-1:0] bs_ff, bs_in;
   logic [CW-1:0] dim_ff, dim_in;
   logic          csr_take;

   // stage a: transferred item
   logic          a_v_ff, a_v_in;
   logic          a_cmd_ff;
   logic [VW-1:0] a_vec_ff;
   logic [PW-1:0] a_idx_ff, a_val_ff;

   // stage b: lane results or a pending table write
   logic          b_v_ff, b_v_in;
   logic          b_cmd_ff;
   logic [VW-1:0] b_epi_ff, b_epi_in;
   logic [PW-1:0] b_idx_ff, b_val_ff;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_bits_ff;

   logic out_ready, b_go, b_free, a_go, a_free, req_take, rsp_load;
   logic sweep_busy;

   bep_pkg::lane_cfg_type    lane_cfg [MAX_DIMENSION];
   logic [MAX_DIMENSION-1:0] lane_en;
   logic [MAX_DIMENSION-1:0] lane_bit;
   logic [VW-1:0]            pfx;
   logic [VW-1:0]            perm;

   //------------------------------------------------------------------
   // Configuration: always ready; any transfer restarts the layout walk
   //------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid & csr_ready;

   always_comb begin
      bs_in  = bs_ff;
      dim_in = dim_ff;
      if (csr_take) begin
         case (csr_index)
            bep_pkg::CSR_BLK_LEN:   bs_in  = csr_wdata;
            bep_pkg::CSR_DIMENSION: dim_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff  <= bep_pkg::BLK_LEN_RESET;
         dim_ff <= bep_pkg::DIMENSION_RESET;
      end else begin
         bs_ff  <= bs_in;
         dim_ff <= dim_in;
      end
   end

   bep_sweep #(.MAX_DIMENSION(MAX_DIMENSION)) u_sweep (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_take),
      .blk_len    (bs_in),
      .dimension  (dim_in),
      .busy       (sweep_busy),
      .lane_cfg   (lane_cfg)
   );

   //------------------------------------------------------------------
   // Flow control: each stage advances when the one after it frees up.
   // A table write leaves stage b without touching the result register.
   //------------------------------------------------------------------
   always_comb begin
      out_ready = !rsp_valid_ff || !rsp_stall;
      b_go      = b_v_ff && (b_cmd_ff == bep_pkg::CMD_WRITE || out_ready);
      b_free    = !b_v_ff || b_go;
      a_go      = a_v_ff && b_free;
      a_free    = !a_v_ff || a_go;
      req_stall = sweep_busy || !a_free;
      req_take  = req_valid && !req_stall;
      rsp_load  = b_go && (b_cmd_ff == bep_pkg::CMD_TRANSFORM);

      a_v_in       = req_take | (a_v_ff & !a_go);
      b_v_in       = a_go | (b_v_ff & !b_go);
      rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff       <= 1'b0;
         b_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_v_ff       <= a_v_in;
         b_v_ff       <= b_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage a payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         a_cmd_ff <= req_command;
         a_vec_ff <= req_vector_bits;
         a_idx_ff <= req_table_index;
         a_val_ff <= req_table_value;
      end
   end

   //------------------------------------------------------------------
   // Lanes: prefix parity over the vector, then one lane per position.
   // Block parity is prefix[end] ^ prefix[start-1]; the lane drops the
   // excluded bit, except in the last bit of a block.
   //------------------------------------------------------------------
   always_comb begin
      pfx = a_vec_ff;
      for (int s = 1; s < VW; s = s * 2) begin
         pfx = pfx ^ (pfx << s);
      end
   end

   for (genvar k = 0; k < MAX_DIMENSION; k++) begin : g_lane
      assign lane_en[k] = lane_cfg[k].valid;
      bep_lane u_lane (
         .prefix  (pfx),
         .vec     (a_vec_ff),
         .cfg     (lane_cfg[k]),
         .epi_bit (lane_bit[k])
      );
   end

   for (genvar k = 0; k < VW; k++) begin : g_pad
      if (k < MAX_DIMENSION) begin : g_used
         assign b_epi_in[k] = lane_bit[k];
      end else begin : g_unused
         assign b_epi_in[k] = 1'b0;
      end
   end

   // stage b payload
   always_ff @(posedge clock) begin
      if (a_go) begin
         b_cmd_ff <= a_cmd_ff;
         b_epi_ff <= b_epi_in;
         b_idx_ff <= a_idx_ff;
         b_val_ff <= a_val_ff;
      end
   end

   //------------------------------------------------------------------
   // Merge: permute the lane results. Table writes commit here, in item
   // order, so a transform ahead of a write still sees the old entry.
   //------------------------------------------------------------------
   bep_permute #(.MAX_DIMENSION(MAX_DIMENSION)) u_permute (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (b_go && (b_cmd_ff == bep_pkg::CMD_WRITE)),
      .wr_idx  (b_idx_ff),
      .wr_val  (b_val_ff),
      .lane_en (lane_en),
      .epi     (b_epi_ff),
      .perm    (perm)
   );

   // result register: hold while stalled
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_bits_ff <= perm;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_bits = rsp_bits_ff;

endmodule

>>> hdl/bep_checker.sv
// Port-level checker of the epistasis-permute block and its bind to the top level.
`include "block_epistasis_permute_macros.svh"

module bep_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [bep_pkg::VEC_W-1:0]     rsp_result_bits,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic [bep_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [bep_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int VW = bep_pkg::VEC_W;
   localparam int CW = bep_pkg::CFG_W;

   logic [CW-1:0] dim_ff, dim_in;
   logic [VW-1:0] dim_mask;

   // track the dimension register from csr transfers
   always_comb begin
      dim_in = dim_ff;
      if (csr_valid && csr_ready && csr_index == bep_pkg::CSR_DIMENSION) begin
         dim_in = csr_wdata;
      end
      dim_mask = (dim_ff >= CW'(VW)) ? '1 : ((VW'(1) << dim_ff) - VW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= bep_pkg::DIMENSION_RESET;
      end else begin
         dim_ff <= dim_in;
      end
   end

   `BEP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_bits), "rsp payload changed under stall")
   `BEP_ASSERT_ALWAYS(a_reset_walk, clock, reset |=> req_stall, "req not stalled during layout walk after reset")
   `BEP_ASSERT(a_csr_walk, clock, reset, csr_valid && csr_ready |=> req_stall, "req not stalled during layout walk after csr transfer")
   `BEP_ASSERT(a_unused_zero, clock, reset, rsp_valid |-> ((rsp_result_bits & ~dim_mask) == '0), "result bits above dimension not zero")

endmodule

bind block_epistasis_permute bep_checker u_bep_checker (.*);

>>> test/tb_block_epistasis_permute.sv
// Self-checking testbench for the epistasis-permute block: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_block_epistasis_permute;

   localparam int VEC_W     = bep_pkg::VEC_W;
   localparam int POS_W     = bep_pkg::POS_W;
   localparam int CFG_W     = bep_pkg::CFG_W;
   localparam int CSR_IDX_W = bep_pkg::CSR_IDX_W;

   // Row kinds of the directed table: reprogram the block layout, or send one item.
   typedef enum {ROW_SETUP, ROW_SEND} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic             cmd;
      logic [VEC_W-1:0] vec;
      logic [POS_W-1:0] idx;
      logic [POS_W-1:0] val;
      logic [CFG_W-1:0] bs;
      logic [CFG_W-1:0] dim;
      bit               typed;   // expected result typed into the row
      logic [VEC_W-1:0] want;
   } stim_row_type;

   localparam int  MAX_DIM        = bep_pkg::DEF_MAX_DIMENSION;
   localparam int  SETTLE_CYCLES  = 8;    // pipeline depth is three, leave margin
   localparam int  RANDOM_PHASES  = 10;
   localparam int  PHASE_ITEMS    = 110;
   localparam int  CLK_HALF       = 10;
   localparam time RUN_LIMIT      = 10_000_000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_command = bep_pkg::CMD_WRITE;
   logic [VEC_W-1:0]     req_vector_bits = '0;
   logic [POS_W-1:0]     req_table_index = '0;
   logic [POS_W-1:0]     req_table_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [VEC_W-1:0]     rsp_result_bits;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = bep_pkg::CSR_BLK_LEN;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // Shadow copy of the block's programmable state, kept in transfer order.
   logic [POS_W-1:0] perm_table [MAX_DIM];
   logic [CFG_W-1:0] cfg_blk_len   = bep_pkg::BLK_LEN_RESET;
   logic [CFG_W-1:0] cfg_dimension = bep_pkg::DIMENSION_RESET;

   // Expected result vectors, oldest first.
   logic [VEC_W-1:0] pending_results [$];
   stim_row_type     directed_rows [$];

   int error_count = 0;
   int burst_left  = 0;
   int rx_cycle    = 0;
   int stall_mode  = 0;
   int hold_left   = 0;

   block_epistasis_permute dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_vector_bits (req_vector_bits),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_bits (rsp_result_bits),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Compute the transformed and permuted vector from the shadow state.
   function automatic logic [VEC_W-1:0] transform_vector(input logic [VEC_W-1:0] vec);
      int               dim;
      int               bs;
      int               h;
      int               v;
      int               i;
      int               j;
      int               k;
      int               src;
      logic [VEC_W-1:0] blk;
      logic [VEC_W-1:0] epi;
      logic [VEC_W-1:0] res;
      logic             par;
      logic             bitval;
      dim = (cfg_dimension > MAX_DIM) ? MAX_DIM : int'(cfg_dimension);
      bs  = (cfg_blk_len == 0) ? 1 : int'(cfg_blk_len);
      if (dim < VEC_W) begin
         vec = vec & ((64'd1 << dim) - 64'd1);
      end
      epi = '0;
      res = '0;
      h   = 0;
      while (h < dim) begin
         v = dim - h;
         if (v > bs) begin
            v = bs;
         end
         blk = vec >> h;
         if (v < VEC_W) begin
            blk = blk & ((64'd1 << v) - 64'd1);
         end
         par = ^blk;
         for (i = 0; i < v; i++) begin
            bitval = par;
            // every bit but the last leaves one block bit out of the parity
            if (i + 1 < v) begin
               j      = v - 1 - ((v - i - 2) & 3);
               bitval = bitval ^ blk[j];
            end
            epi[h + i] = bitval;
         end
         h = h + v;
      end
      for (k = 0; k < dim; k++) begin
         src = int'(perm_table[k]);
         // entries that point past the active dimension read zero
         if (src < dim) begin
            res[k] = epi[src];
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [VEC_W-1:0] want,
                                  input logic [VEC_W-1:0] got);
      $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
      error_count++;
   endtask

   function automatic void add_setup(input logic [CFG_W-1:0] bs, input logic [CFG_W-1:0] dim);
      stim_row_type row;
      row       = '{kind: ROW_SETUP, cmd: bep_pkg::CMD_WRITE, vec: '0, idx: '0, val: '0,
                    bs: bs, dim: dim, typed: 1'b0, want: '0};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_item(input logic cmd, input logic [VEC_W-1:0] vec,
                                    input logic [POS_W-1:0] idx, input logic [POS_W-1:0] val,
                                    input bit typed, input logic [VEC_W-1:0] want);
      stim_row_type row;
      row = '{kind: ROW_SEND, cmd: cmd, vec: vec, idx: idx, val: val,
              bs: '0, dim: '0, typed: typed, want: want};
      directed_rows.push_back(row);
   endfunction

   // Sender pacing: bursts of random length, separated by random idle gaps.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
   endtask

   // Present one item, hold it until the transfer, then update the shadow state.
   task automatic send_item(input logic cmd, input logic [VEC_W-1:0] vec,
                            input logic [POS_W-1:0] idx, input logic [POS_W-1:0] val,
                            input bit typed, input logic [VEC_W-1:0] want);
      pace_sender();
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_vector_bits <= vec;
      req_table_index <= idx;
      req_table_value <= val;
      do @(posedge clock); while (req_stall);
      if (cmd == bep_pkg::CMD_WRITE) begin
         perm_table[idx] = val;
      end else begin
         pending_results.push_back(typed ? want : transform_vector(vec));
      end
   endtask

   // Drop valid, drain every expected result, and let trailing writes retire.
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Present one register write and hold it until the transfer; the caller drops valid.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == bep_pkg::CSR_BLK_LEN) begin
         cfg_blk_len = data;
      end else if (idx == bep_pkg::CSR_DIMENSION) begin
         cfg_dimension = data;
      end
   endtask

   task automatic program_layout(input logic [CFG_W-1:0] bs, input logic [CFG_W-1:0] dim);
      settle();
      csr_write(bep_pkg::CSR_BLK_LEN, bs);
      csr_write(bep_pkg::CSR_DIMENSION, dim);
      csr_valid <= 1'b0;
   endtask

   // Receiver: check each result transfer, then pick the next stall value.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", '0, rsp_result_bits);
         end else if (rsp_result_bits !== pending_results[0]) begin
            report_mismatch("result_bits", pending_results.pop_front(), rsp_result_bits);
         end else begin
            void'(pending_results.pop_front());
         end
      end
      rx_cycle++;
      if (rx_cycle % 64 == 0) begin
         stall_mode = $urandom_range(0, 3);
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 1) == 1);
            end
            2: begin
               rsp_stall <= (rx_cycle % 3 == 0);
            end
            default: begin
               // long holds now and then
               if (hold_left > 0) begin
                  hold_left--;
                  rsp_stall <= 1'b1;
               end else if ($urandom_range(0, 7) == 0) begin
                  hold_left = $urandom_range(5, 20);
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
         endcase
      end
   end

   initial begin
      stim_row_type     row;
      int               p;
      int               n;
      logic             cmd;
      logic [VEC_W-1:0] vec;
      logic [CFG_W-1:0] bs;
      logic [CFG_W-1:0] dim;

      for (n = 0; n < MAX_DIM; n++) begin
         perm_table[n] = POS_W'(n);
      end

      // Reset state: unit blocks and identity permutation pass vectors through.
      add_item(bep_pkg::CMD_TRANSFORM, 64'h0, 6'd0, 6'd0, 1'b1, 64'h0);
      add_item(bep_pkg::CMD_TRANSFORM, '1, 6'd63, 6'd63, 1'b1, '1);
      add_item(bep_pkg::CMD_TRANSFORM, 64'h8000_0000_0000_0001, 6'd0, 6'd0, 1'b1,
               64'h8000_0000_0000_0001);
      add_item(bep_pkg::CMD_TRANSFORM, 64'hDEAD_BEEF_0123_4567, 6'd5, 6'd9, 1'b1,
               64'hDEAD_BEEF_0123_4567);
      // Swap the two end entries: bit 0 moves to the top.
      add_item(bep_pkg::CMD_WRITE, '1, 6'd0, 6'd63, 1'b0, '0);
      add_item(bep_pkg::CMD_WRITE, '0, 6'd63, 6'd0, 1'b0, '0);
      add_item(bep_pkg::CMD_TRANSFORM, 64'h1, 6'd0, 6'd0, 1'b1, 64'h8000_0000_0000_0000);
      add_item(bep_pkg::CMD_WRITE, '0, 6'd0, 6'd0, 1'b0, '0);
      add_item(bep_pkg::CMD_WRITE, '1, 6'd63, 6'd63, 1'b0, '0);
      // Zero block length acts as one.
      add_setup(7'd0, 7'd64);
      add_item(bep_pkg::CMD_TRANSFORM, '1, 6'd0, 6'd0, 1'b1, '1);
      // One block spanning the whole vector.
      add_setup(7'd64, 7'd64);
      add_item(bep_pkg::CMD_TRANSFORM, 64'h0, 6'd0, 6'd0, 1'b1, 64'h0);
      add_item(bep_pkg::CMD_TRANSFORM, '1, 6'd0, 6'd0, 1'b0, '0);
      // Block larger than the vector.
      add_setup(7'd127, 7'd20);
      add_item(bep_pkg::CMD_TRANSFORM, 64'hC3A5_0F1E_9B7D_2468, 6'd0, 6'd0, 1'b0, '0);
      // Zero dimension gives zero.
      add_setup(7'd4, 7'd0);
      add_item(bep_pkg::CMD_TRANSFORM, '1, 6'd0, 6'd0, 1'b1, 64'h0);
      // Dimension above the maximum saturates.
      add_setup(7'd4, 7'd127);
      add_item(bep_pkg::CMD_TRANSFORM, 64'h0123_4567_89AB_CDEF, 6'd0, 6'd0, 1'b0, '0);
      // Bits above the dimension are ignored; an entry past it reads zero.
      add_setup(7'd1, 7'd8);
      add_item(bep_pkg::CMD_TRANSFORM, '1, 6'd0, 6'd0, 1'b1, 64'hFF);
      add_item(bep_pkg::CMD_WRITE, '0, 6'd3, 6'd40, 1'b0, '0);
      add_item(bep_pkg::CMD_TRANSFORM, '1, 6'd0, 6'd0, 1'b1, 64'hF7);
      add_item(bep_pkg::CMD_WRITE, '0, 6'd3, 6'd3, 1'b0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.kind == ROW_SETUP) begin
            program_layout(row.bs, row.dim);
         end else begin
            send_item(row.cmd, row.vec, row.idx, row.val, row.typed, row.want);
         end
      end

      // Random phases: new layout per phase, mixed table writes and transforms.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 9))
            0: bs = 7'd0;
            1: bs = 7'd1;
            2: bs = 7'd64;
            3: bs = CFG_W'($urandom_range(65, 127));
            4, 5: bs = CFG_W'($urandom_range(1, 64));
            default: bs = CFG_W'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 9))
            0: dim = 7'd0;
            1: dim = 7'd1;
            2, 3: dim = 7'd64;
            4: dim = CFG_W'($urandom_range(65, 127));
            default: dim = CFG_W'($urandom_range(1, 64));
         endcase
         program_layout(bs, dim);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            cmd = ($urandom_range(0, 3) == 0) ? bep_pkg::CMD_WRITE : bep_pkg::CMD_TRANSFORM;
            case ($urandom_range(0, 7))
               0: vec = '0;
               1: vec = '1;
               2: vec = 64'd1 << $urandom_range(0, 63);
               default: vec = {$urandom, $urandom};
            endcase
            send_item(cmd, vec, POS_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)),
                      1'b0, '0);
         end
      end

      settle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/bep_pkg.sv
hdl/bep_sweep.sv
hdl/bep_lane.sv
hdl/bep_permute.sv
hdl/block_epistasis_permute.sv
hdl/bep_checker.sv
test/tb_block_epistasis_permute.sv
